// ----- design/pcpu_pkg.sv -----
`default_nettype none

package pcpu_pkg;

  localparam logic [2:0] MODE_1BPP  = 3'd0;
  localparam logic [2:0] MODE_4BPP  = 3'd1;
  localparam logic [2:0] MODE_8BPP  = 3'd2;
  localparam logic [2:0] MODE_24BPP = 3'd3;
  localparam logic [2:0] MODE_32BPP = 3'd4;

  localparam logic OP_PALETTE_WRITE = 1'b0;
  localparam logic OP_PIXEL         = 1'b1;

  localparam int CfgIndexBits = 2;
  localparam logic [CfgIndexBits-1:0] REG_PIXEL_MODE      = 2'd0;
  localparam logic [CfgIndexBits-1:0] REG_COLOR_KEY       = 2'd1;
  localparam logic [CfgIndexBits-1:0] REG_MASK_ENABLE     = 2'd2;
  localparam logic [CfgIndexBits-1:0] REG_MASK_SKIP_VALUE = 2'd3;

  localparam logic [2:0]  RESET_PIXEL_MODE = MODE_8BPP;
  localparam logic [31:0] DIRECT24_MASK    = 32'h00ff_ffff;

  typedef struct packed {
    logic        op;
    logic [7:0]  palette_slot;
    logic [31:0] palette_color;
    logic [31:0] source_bytes;
    logic [2:0]  bit_position;
    logic        mask_bit;
    logic [23:0] dest_address;
  } request_t;

  typedef struct packed {
    logic [23:0] out_address;
    logic [31:0] out_color;
  } result_t;

endpackage

`default_nettype wire

// ----- design/palette_colorkey_pixel_unpack_unit.sv -----
`default_nettype none

// channel   dir  handshake            payload
// pixel     in   pixel_valid/stall    pcpu_pkg::request_t
// result    out  result_valid/stall   pcpu_pkg::result_t
// cfg       in   cfg_valid/ready      cfg_index, cfg_data
//
// one request per cycle while pixel_stall is low; a pixel result passes through
// the palette ram read stage and then the output register
// rst is synchronous and clears config to defaults and both valid stages
// the palette is not cleared; a lookup of an unwritten entry is undefined
// a stalled result holds; the ram read stage still takes one more request

module palette_colorkey_pixel_unpack_unit #(
  parameter int PALETTE_DEPTH = 256,
  parameter int ADDRESS_BITS  = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                pixel_valid,
  output logic                                     pixel_stall,
  input  wire pcpu_pkg::request_t                  pixel,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output pcpu_pkg::result_t                        result,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pcpu_pkg::CfgIndexBits-1:0]   cfg_index,
  input  wire logic [31:0]                         cfg_data
);

  localparam int IdxBits  = $clog2(PALETTE_DEPTH);
  localparam int AddrKeep = (ADDRESS_BITS < 24) ? ADDRESS_BITS : 24;

  logic [2:0]  pixel_mode;
  logic [31:0] color_key;
  logic        mask_enable;
  logic        mask_skip_value;

  logic                pixel_accept;
  logic                palette_write;
  logic                pixel_req;
  logic                mode_valid;
  logic                indexed;
  logic [7:0]          index;
  logic [31:0]         value;
  logic                keep;
  logic [7:0]          byte0;

  logic                hold_valid;
  logic                hold_move;
  logic                hold_indexed;
  logic                hold_oob;
  logic [31:0]         hold_direct;
  logic [AddrKeep-1:0] hold_address;
  logic [31:0]         ram_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode      <= pcpu_pkg::RESET_PIXEL_MODE;
      color_key       <= '0;
      mask_enable     <= 1'b0;
      mask_skip_value <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcpu_pkg::REG_PIXEL_MODE:      pixel_mode      <= cfg_data[2:0];
        pcpu_pkg::REG_COLOR_KEY:       color_key       <= cfg_data;
        pcpu_pkg::REG_MASK_ENABLE:     mask_enable     <= cfg_data[0];
        pcpu_pkg::REG_MASK_SKIP_VALUE: mask_skip_value <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign hold_move    = !result_valid || !result_stall;
  assign pixel_stall  = hold_valid && !hold_move;
  assign pixel_accept = pixel_valid && !pixel_stall;
  assign palette_write = pixel_accept && (pixel.op == pcpu_pkg::OP_PALETTE_WRITE) &&
                         ({1'b0, pixel.palette_slot} < 9'(PALETTE_DEPTH));
  assign pixel_req    = pixel_accept && (pixel.op == pcpu_pkg::OP_PIXEL);
  assign byte0        = pixel.source_bytes[7:0];

  // pixel decode
  always_comb begin
    mode_valid = 1'b1;
    indexed    = 1'b1;
    index      = '0;
    value      = '0;
    unique case (pixel_mode)
      pcpu_pkg::MODE_1BPP: index = {7'd0, byte0[3'd7 - pixel.bit_position]};
      pcpu_pkg::MODE_4BPP: index = {4'd0, pixel.bit_position[0] ? byte0[3:0] : byte0[7:4]};
      pcpu_pkg::MODE_8BPP: index = byte0;
      pcpu_pkg::MODE_24BPP: begin
        indexed = 1'b0;
        value   = pixel.source_bytes & pcpu_pkg::DIRECT24_MASK;
      end
      pcpu_pkg::MODE_32BPP: begin
        indexed = 1'b0;
        value   = pixel.source_bytes;
      end
      default: mode_valid = 1'b0;
    endcase
    if (indexed) begin
      value = {24'd0, index};
    end
    if (mask_enable) begin
      keep = (pixel_mode == pcpu_pkg::MODE_4BPP) && (pixel.mask_bit != mask_skip_value);
    end else begin
      keep = mode_valid && (value != color_key);
    end
  end

  pcpu_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr_en  (palette_write),
    .wr_addr(pixel.palette_slot[IdxBits-1:0]),
    .wr_data(pixel.palette_color),
    .rd_en  (pixel_req),
    .rd_addr(index[IdxBits-1:0]),
    .rd_data(ram_rd_data)
  );

  // ram read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hold_move || !hold_valid) begin
      hold_valid <= pixel_req && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_req) begin
      hold_indexed <= indexed;
      hold_oob     <= {1'b0, index} >= 9'(PALETTE_DEPTH);
      hold_direct  <= value;
      hold_address <= pixel.dest_address[AddrKeep-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (hold_move) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_move && hold_valid) begin
      result.out_address <= 24'(hold_address);
      if (hold_indexed) begin
        result.out_color <= hold_oob ? 32'd0 : ram_rd_data;
      end else begin
        result.out_color <= hold_direct;
      end
    end
  end

  a_kept_pixel_held: assert property (@(posedge clk) disable iff (rst)
    pixel_req && keep |=> hold_valid)
    else $error("kept pixel lost after palette read");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    pixel_accept && (pixel.op == pcpu_pkg::OP_PALETTE_WRITE) |=> !hold_valid)
    else $error("palette write produced a result");

  a_read_data_held: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !hold_move |=> $stable(ram_rd_data))
    else $error("palette read data changed under stall");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(hold_valid))
    else $error("result without a pending pixel");

endmodule

`default_nettype wire

// ----- design/pcpu_ram.sv -----
`default_nettype none

module pcpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
